### rtl/core/periodic_minimum_image_smith_top_defines.svh
// Assertion macros for the periodic minimum-image block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef PERIODIC_MINIMUM_IMAGE_SMITH_TOP_DEFINES_SVH
`define PERIODIC_MINIMUM_IMAGE_SMITH_TOP_DEFINES_SVH

// same-cycle implication
`define PMIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error(msg);

// next-cycle implication
`define PMIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error(msg);

`endif

### rtl/core/pmis_pkg.sv
// Shared widths, defaults and register indexes for the minimum-image block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pmis_pkg;

   localparam int POS_W            = 32;  // Q15.16 position and result fields
   localparam int ENTRY_W          = 21;  // one packed signed matrix entry
   localparam int CFG_W            = 63;  // three entries per register
   localparam int MASK_W           = 3;
   localparam int CSR_INDEX_W      = 3;
   localparam int COORD_W          = 40;  // clamped fractional coordinate
   localparam int POS_FRAC_DEFAULT = 16;
   localparam int MAT_FRAC_DEFAULT = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CELL_A,
      CSR_CELL_B,
      CSR_CELL_C,
      CSR_INV_0,
      CSR_INV_1,
      CSR_INV_2,
      CSR_MASK
   } csr_index_type;

   typedef logic signed [POS_W-1:0]   pos_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic [CFG_W-1:0]          cfg_type;

   function automatic entry_type entry_of(input cfg_type packed_reg, input logic [1:0] slot);
      entry_type e;
      e = '0;
      case (slot)
         2'd0:    e = entry_type'(packed_reg[ENTRY_W-1:0]);
         2'd1:    e = entry_type'(packed_reg[2*ENTRY_W-1:ENTRY_W]);
         2'd2:    e = entry_type'(packed_reg[3*ENTRY_W-1:2*ENTRY_W]);
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

### rtl/core/pmis_req_if.sv
// Input channel: a pair of positions with valid/ready handshake.
// Depends on pmis_pkg.
`default_nettype none

interface pmis_req_if import pmis_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type first_x;
   pos_type first_y;
   pos_type first_z;
   pos_type second_x;
   pos_type second_y;
   pos_type second_z;

   modport source (output valid, first_x, first_y, first_z,
                   second_x, second_y, second_z, input ready);
   modport sink   (input valid, first_x, first_y, first_z,
                   second_x, second_y, second_z, output ready);
endinterface

`default_nettype wire

### rtl/core/pmis_rsp_if.sv
// Result channel: one minimum-image displacement with valid/ready handshake.
// Depends on pmis_pkg.
`default_nettype none

interface pmis_rsp_if import pmis_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type sep_x;
   pos_type sep_y;
   pos_type sep_z;

   modport source (output valid, sep_x, sep_y, sep_z, input ready);
   modport sink   (input valid, sep_x, sep_y, sep_z, output ready);
endinterface

`default_nettype wire

### rtl/core/periodic_minimum_image_smith_top.sv
// Minimum-image displacement in a periodic, skewed cell (Smith's method).
// Throughput one item per cycle while the output is not stalled.
// Eight register stages, each with its own valid bit; a stalled output lets
// bubbles upstream fill, so items keep entering until all stages hold one.
// Reset (synchronous): pipeline emptied, cell and inverse set to identity, all axes periodic.
// Depends on pmis_pkg, pmis_req_if, pmis_rsp_if and the defines header.
`default_nettype none

`include "periodic_minimum_image_smith_top_defines.svh"

module periodic_minimum_image_smith_top
   import pmis_pkg::*;
#(
   parameter int POSITION_FRACTION_BITS = POS_FRAC_DEFAULT,
   parameter int MATRIX_FRACTION_BITS   = MAT_FRAC_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata,
   pmis_req_if.sink                    req,
   pmis_rsp_if.source                  rsp
);

   // ---------------------------------------------------------------------------
   // Widths
   //   stage 1: d = first - second                       (D_W)
   //   stage 2: nine products inv * d                    (P1_W)
   //   stage 3: row sums, fractional coord with FB frac  (ACC_W)
   //   stage 4: trunc(2s) and rounding bias, in parallel
   //   stage 5: wrap, round by M, clamp to COORD_W
   //   stage 6: cell * s, s split in two halves to keep multipliers small
   //   stage 7: half sums (low half carries the rounding bias)
   //   stage 8: recombine, round, saturate, or pass d when no axis is periodic
   // ---------------------------------------------------------------------------
   localparam int NS       = 8;
   localparam int FB       = POSITION_FRACTION_BITS + MATRIX_FRACTION_BITS;
   localparam int D_W      = POS_W + 1;
   localparam int P1_W     = ENTRY_W + D_W;
   localparam int ACC_W    = P1_W + 2;
   localparam int T_W      = ACC_W - FB + 1;
   localparam int SPLIT    = COORD_W / 2;
   localparam int PLO_W    = ENTRY_W + SPLIT + 1;
   localparam int PHI_W    = ENTRY_W + COORD_W - SPLIT;
   localparam int LO_SUM_W = PLO_W + 2;
   localparam int HI_SUM_W = PHI_W + 2;
   localparam int TOT_W    = HI_SUM_W + SPLIT + 1;

   localparam logic signed [ACC_W-1:0] TR_BIAS = (ACC_W'(1) << (FB - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] RND_ACC = ACC_W'(1) << (MATRIX_FRACTION_BITS - 1);
   localparam logic signed [ACC_W-1:0] S_HI    =
      {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] S_LO    = -S_HI;
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [LO_SUM_W-1:0] RND_LO = LO_SUM_W'(1) << (MATRIX_FRACTION_BITS - 1);
   localparam logic signed [TOT_W-1:0] OUT_MAX =
      {{(TOT_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
   localparam logic signed [TOT_W-1:0] OUT_MIN = -OUT_MAX - TOT_W'(1);

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   cfg_type           cfg_cell_ff [3];
   cfg_type           cfg_inv_ff  [3];
   logic [MASK_W-1:0] cfg_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            cfg_cell_ff[i] <= CFG_W'(1) << (i * ENTRY_W + MATRIX_FRACTION_BITS);
            cfg_inv_ff[i]  <= CFG_W'(1) << (i * ENTRY_W + MATRIX_FRACTION_BITS);
         end
         cfg_mask_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CELL_A: cfg_cell_ff[0] <= csr_wdata;
            CSR_CELL_B: cfg_cell_ff[1] <= csr_wdata;
            CSR_CELL_C: cfg_cell_ff[2] <= csr_wdata;
            CSR_INV_0:  cfg_inv_ff[0]  <= csr_wdata;
            CSR_INV_1:  cfg_inv_ff[1]  <= csr_wdata;
            CSR_INV_2:  cfg_inv_ff[2]  <= csr_wdata;
            CSR_MASK:   cfg_mask_ff    <= csr_wdata[MASK_W-1:0];
            default:    ;  // index past the list: ignored
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline flow control: a stage loads when empty or when the next one loads.
   // ---------------------------------------------------------------------------
   logic [NS:1]   vld_ff;
   logic [NS+1:1] en;

   always_comb begin
      en[NS+1] = rsp.ready;
      for (int i = NS; i >= 1; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req.ready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) begin
            vld_ff[1] <= req.valid;
         end
         for (int i = 2; i <= NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // d travels along for the open-system case
   logic signed [D_W-1:0] d_ff [1:NS-1][3];

   // ---------------------------------------------------------------------------
   // Stage 1: difference
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (en[1]) begin
         d_ff[1][0] <= D_W'(req.first_x) - D_W'(req.second_x);
         d_ff[1][1] <= D_W'(req.first_y) - D_W'(req.second_y);
         d_ff[1][2] <= D_W'(req.first_z) - D_W'(req.second_z);
      end
      for (int i = 2; i <= NS - 1; i++) begin
         if (en[i]) begin
            d_ff[i] <= d_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: inverse products
   // ---------------------------------------------------------------------------
   logic signed [P1_W-1:0] p1_in [3][3];
   logic signed [P1_W-1:0] p1_ff [3][3];

   always_comb begin
      for (int n = 0; n < 3; n++) begin
         for (int k = 0; k < 3; k++) begin
            p1_in[n][k] = P1_W'(entry_of(cfg_inv_ff[n], 2'(k))) * P1_W'(d_ff[1][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         p1_ff <= p1_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: row sums
   // ---------------------------------------------------------------------------
   logic signed [ACC_W-1:0] acc_in [3];
   logic signed [ACC_W-1:0] acc_ff [3];

   always_comb begin
      for (int n = 0; n < 3; n++) begin
         acc_in[n] = ACC_W'(p1_ff[n][0]) + ACC_W'(p1_ff[n][1]) + ACC_W'(p1_ff[n][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         acc_ff <= acc_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: trunc(2s) toward zero (bias negatives before the shift) and
   // the rounding bias for the later shift by M
   // ---------------------------------------------------------------------------
   logic signed [ACC_W-1:0] adj     [3];
   logic signed [ACC_W-1:0] tshift  [3];
   logic signed [T_W-1:0]   t_in    [3];
   logic signed [ACC_W-1:0] half_in [3];
   logic signed [T_W-1:0]   t_ff    [3];
   logic signed [ACC_W-1:0] half_ff [3];

   always_comb begin
      for (int n = 0; n < 3; n++) begin
         adj[n]     = acc_ff[n] + (acc_ff[n][ACC_W-1] ? TR_BIAS : ACC_W'(0));
         tshift[n]  = adj[n] >>> (FB - 1);
         t_in[n]    = cfg_mask_ff[n] ? T_W'(tshift[n][T_W-1:0]) : T_W'(0);
         half_in[n] = acc_ff[n] + RND_ACC;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         t_ff    <= t_in;
         half_ff <= half_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: wrap, round, clamp
   // ---------------------------------------------------------------------------
   logic signed [ACC_W-1:0]   wrap [3];
   logic signed [ACC_W-1:0]   srnd [3];
   logic signed [COORD_W-1:0] s_in [3];
   logic signed [COORD_W-1:0] s_ff [3];

   always_comb begin
      for (int n = 0; n < 3; n++) begin
         wrap[n] = half_ff[n] - (ACC_W'(t_ff[n]) <<< FB);
         srnd[n] = wrap[n] >>> MATRIX_FRACTION_BITS;
         if (srnd[n] > S_HI) begin
            s_in[n] = COORD_W'(S_HI);
         end else if (srnd[n] < S_LO) begin
            s_in[n] = COORD_W'(S_LO);
         end else begin
            s_in[n] = srnd[n][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s_ff <= s_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 6: cell products on split coordinates
   // ---------------------------------------------------------------------------
   logic signed [SPLIT:0]           s_lo   [3];
   logic signed [COORD_W-SPLIT-1:0] s_hi   [3];
   logic signed [PLO_W-1:0]         plo_in [3][3];
   logic signed [PHI_W-1:0]         phi_in [3][3];
   logic signed [PLO_W-1:0]         plo_ff [3][3];
   logic signed [PHI_W-1:0]         phi_ff [3][3];

   always_comb begin
      for (int n = 0; n < 3; n++) begin
         s_lo[n] = {1'b0, s_ff[n][SPLIT-1:0]};
         s_hi[n] = s_ff[n][COORD_W-1:SPLIT];
      end
      for (int k = 0; k < 3; k++) begin
         for (int n = 0; n < 3; n++) begin
            plo_in[k][n] = PLO_W'(entry_of(cfg_cell_ff[n], 2'(k))) * PLO_W'(s_lo[n]);
            phi_in[k][n] = PHI_W'(entry_of(cfg_cell_ff[n], 2'(k))) * PHI_W'(s_hi[n]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 7: half sums
   // ---------------------------------------------------------------------------
   logic signed [LO_SUM_W-1:0] lo_in [3];
   logic signed [HI_SUM_W-1:0] hi_in [3];
   logic signed [LO_SUM_W-1:0] lo_ff [3];
   logic signed [HI_SUM_W-1:0] hi_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_in[k] = LO_SUM_W'(plo_ff[k][0]) + LO_SUM_W'(plo_ff[k][1])
                  + LO_SUM_W'(plo_ff[k][2]) + RND_LO;
         hi_in[k] = HI_SUM_W'(phi_ff[k][0]) + HI_SUM_W'(phi_ff[k][1])
                  + HI_SUM_W'(phi_ff[k][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 8: recombine, round, saturate; output register
   // ---------------------------------------------------------------------------
   logic signed [TOT_W-1:0] total [3];
   logic signed [TOT_W-1:0] pre   [3];
   pos_type                 out_in [3];
   pos_type                 out_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         total[k] = (TOT_W'(hi_ff[k]) <<< SPLIT) + TOT_W'(lo_ff[k]);
         if (cfg_mask_ff == '0) begin
            pre[k] = TOT_W'(d_ff[NS-1][k]);   // open system: plain difference
         end else begin
            pre[k] = total[k] >>> MATRIX_FRACTION_BITS;
         end
         if (pre[k] > OUT_MAX) begin
            out_in[k] = POS_W'(OUT_MAX);
         end else if (pre[k] < OUT_MIN) begin
            out_in[k] = POS_W'(OUT_MIN);
         end else begin
            out_in[k] = pre[k][POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid = vld_ff[NS];
   assign rsp.sep_x = out_ff[0];
   assign rsp.sep_y = out_ff[1];
   assign rsp.sep_z = out_ff[2];

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   `PMIS_ASSERT_NOW(a_full_blocks_input, clock, reset, (&vld_ff) && !rsp.ready, !req.ready, "input taken while pipeline full and output stalled")
   `PMIS_ASSERT_NEXT(a_accept_fills_stage1, clock, reset, req.valid && req.ready, vld_ff[1], "accepted item missing from first stage")
   `PMIS_ASSERT_NOW(a_coord_clamped, clock, reset, vld_ff[5], (s_ff[0] != COORD_MIN) && (s_ff[1] != COORD_MIN) && (s_ff[2] != COORD_MIN), "fractional coordinate outside clamp range")

endmodule

`default_nettype wire

### test/periodic_minimum_image_smith_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for periodic_minimum_image_smith_top: a directed table, then random
// phases over several cells; results checked against typed values or a Smith predictor.
// Depends on pmis_pkg, pmis_req_if, pmis_rsp_if and the top level.
module periodic_minimum_image_smith_top_tb
   import pmis_pkg::*;
();

   localparam int     POS_FRAC        = POS_FRAC_DEFAULT;
   localparam int     MAT_FRAC        = MAT_FRAC_DEFAULT;
   localparam int     WRAP_SHIFT      = POS_FRAC + MAT_FRAC;   // fraction bits of s
   localparam longint COORD_MAX       = (longint'(1) <<< (COORD_W - 1)) - 1;
   localparam longint SEP_MAX         = 64'sd2147483647;
   localparam longint SEP_MIN         = -64'sd2147483648;
   localparam int     UNIT            = 1 << MAT_FRAC;        // 1.0 in Q8.12
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;     // past the register list
   localparam int     PIPE_LATENCY    = 8;
   localparam int     IDLE_LIMIT      = 2000;
   localparam int     HOLD_CYCLES     = 64;
   localparam int     PHASES          = 10;
   localparam int     ITEMS_PER_PHASE = 85;
   localparam int     MAX_PRINTED     = 100;

   typedef struct packed {
      pos_type fx, fy, fz;
      pos_type sx, sy, sz;
   } position_pair_type;

   typedef struct packed {
      pos_type x, y, z;
   } separation_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      position_pair_type pair;
      logic              typed;   // expected value written out below
      separation_type    sep;
   } directed_row_type;

   typedef struct {
      logic [CSR_INDEX_W-1:0] idx;
      cfg_type                val;
   } csr_write_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   pmis_req_if req_ch ();
   pmis_rsp_if rsp_ch ();

   periodic_minimum_image_smith_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   // bench copy of the register file
   cfg_type           cell_m [3];
   cfg_type           inv_m  [3];
   logic [MASK_W-1:0] mask_m;

   separation_type expected_seps [$];
   int          mismatches    = 0;
   int          results_seen  = 0;
   int          pressure_count = 0;   // bumped (NBA) to ask the receiver for a long hold
   bit          send_idle_on  = 1'b0;
   bit          rsp_idle_on   = 1'b0;

   // Directed items. Cell and inverse stay at identity here, so the wrap can be read
   // off directly: s - trunc(2s) sends 0.5 to -0.5, 1.0 to -1.0, 1.25 to -0.75.
   directed_row_type directed_rows [17] = '{
      // all periodic: zero, quarter, half, whole, and the odd-quarter wraps
      '{3'd7, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        1'b1, '{32'h0, 32'h0, 32'h0}},
      '{3'd7, '{32'h4000, 32'h0, 32'h0, 32'h0, 32'h4000, 32'h0},
        1'b1, '{32'h4000, 32'hFFFFC000, 32'h0}},
      '{3'd7, '{32'h8000, 32'h0, 32'h10000, 32'h0, 32'h8000, 32'h0},
        1'b1, '{32'hFFFF8000, 32'h8000, 32'hFFFF0000}},
      '{3'd7, '{32'hC000, 32'h14000, 32'h0, 32'h0, 32'h0, 32'h14000},
        1'b1, '{32'hFFFFC000, 32'hFFFF4000, 32'hC000}},
      // position extremes, one least-significant step, alternating bits
      '{3'd7, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, '0},
      '{3'd7, '{32'h80000000, 32'h80000000, 32'h80000000,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, '0},
      '{3'd7, '{32'h7FFFFFFF, 32'h0, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h0},
        1'b0, '0},
      '{3'd7, '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0},
        1'b0, '0},
      '{3'd7, '{32'h55555555, 32'hAAAAAAAA, 32'h55555555,
                32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA}, 1'b0, '0},
      // open system: plain difference, saturated
      '{3'd0, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h80000000, 32'h80000000, 32'h80000000},
        1'b1, '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}},
      '{3'd0, '{32'h80000000, 32'h80000000, 32'h80000000,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
        1'b1, '{32'h80000000, 32'h80000000, 32'h80000000}},
      '{3'd0, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
        1'b1, '{32'h0, 32'h0, 32'h0}},
      '{3'd0, '{32'h18000, 32'hFFFD0000, 32'h12345678, 32'h0, 32'h0, 32'h0},
        1'b1, '{32'h18000, 32'hFFFD0000, 32'h12345678}},
      // partly periodic: only the masked axes wrap
      '{3'd1, '{32'h8000, 32'h8000, 32'h10000, 32'h0, 32'h0, 32'h0},
        1'b1, '{32'hFFFF8000, 32'h8000, 32'h10000}},
      '{3'd6, '{32'h8000, 32'h8000, 32'h10000, 32'h0, 32'h0, 32'h0},
        1'b1, '{32'h8000, 32'hFFFF8000, 32'hFFFF0000}},
      '{3'd5, '{32'h18000, 32'h18000, 32'h18000, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
      '{3'd7, '{32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0},
        1'b0, '0}
   };

   // ---------------------------------------------------------------- predictor

   function automatic longint matrix_entry(cfg_type packed_reg, int slot);
      return longint'($signed(packed_reg[slot*ENTRY_W +: ENTRY_W]));
   endfunction

   // round to nearest, ties toward +inf, dropping the matrix fraction bits
   function automatic longint drop_matrix_frac(longint v);
      return (v + (longint'(1) <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
   endfunction

   function automatic pos_type saturate_pos(longint v);
      if (v > SEP_MAX) return pos_type'(SEP_MAX);
      if (v < SEP_MIN) return pos_type'(SEP_MIN);
      return pos_type'(v);
   endfunction

   function automatic separation_type min_image(position_pair_type p);
      longint  d [3];
      longint  s [3];
      longint  acc;
      longint  wraps;
      pos_type r [3];
      d[0] = longint'($signed(p.fx)) - longint'($signed(p.sx));
      d[1] = longint'($signed(p.fy)) - longint'($signed(p.sy));
      d[2] = longint'($signed(p.fz)) - longint'($signed(p.sz));
      if (mask_m == '0) begin
         for (int n = 0; n < 3; n++) r[n] = saturate_pos(d[n]);
      end else begin
         // fractional coordinates, wrapped on periodic axes
         for (int n = 0; n < 3; n++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += matrix_entry(inv_m[n], k) * d[k];
            if (mask_m[n]) begin
               wraps = (acc >= 0) ? (acc >>> (WRAP_SHIFT - 1))
                                  : -((-acc) >>> (WRAP_SHIFT - 1));
               acc -= wraps <<< WRAP_SHIFT;
            end
            acc = drop_matrix_frac(acc);
            s[n] = (acc > COORD_MAX) ? COORD_MAX : ((acc < -COORD_MAX) ? -COORD_MAX : acc);
         end
         // back to Cartesian
         for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int n = 0; n < 3; n++) acc += matrix_entry(cell_m[n], k) * s[n];
            r[k] = saturate_pos(drop_matrix_frac(acc));
         end
      end
      return '{r[0], r[1], r[2]};
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic cfg_type pack_entries(int ex, int ey, int ez);
      logic [ENTRY_W-1:0] px, py, pz;
      px = ex[ENTRY_W-1:0];
      py = ey[ENTRY_W-1:0];
      pz = ez[ENTRY_W-1:0];
      return {pz, py, px};
   endfunction

   function automatic cfg_type unit_column(int slot);
      return cfg_type'(UNIT) << (ENTRY_W * slot);
   endfunction

   function automatic int to_matrix_fixed(real v);
      return $rtoi(v * real'(UNIT) + ((v >= 0.0) ? 0.5 : -0.5));
   endfunction

   // mostly no gap, some short, a few long
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // well-formed coordinate within +-span, with some full-range noise
   function automatic pos_type rand_coord(int unsigned span);
      if ($urandom_range(0, 9) == 0) return pos_type'($urandom);
      return pos_type'(longint'($urandom_range(0, 2 * span)) - longint'(span));
   endfunction

   function automatic position_pair_type rand_pair(int unsigned span);
      return '{rand_coord(span), rand_coord(span), rand_coord(span),
               rand_coord(span), rand_coord(span), rand_coord(span)};
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("mismatch at result %0d, %s: got %h, want %h", results_seen, what, got, want);
   endtask

   // ---------------------------------------------------------------- drivers

   // offer one pair, hold it until accepted, then record what it must produce
   task automatic offer_pair(position_pair_type p, logic typed, separation_type want);
      int unsigned gap;
      req_ch.valid    <= 1'b1;
      req_ch.first_x  <= p.fx;
      req_ch.first_y  <= p.fy;
      req_ch.first_z  <= p.fz;
      req_ch.second_x <= p.sx;
      req_ch.second_y <= p.sy;
      req_ch.second_z <= p.sz;
      do @(posedge clock); while (!req_ch.ready);
      expected_seps.push_back(typed ? want : min_image(p));
      gap = send_idle_on ? idle_gap() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait until every pending result is back
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_seps.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csrs(csr_write_type writes [$]);
      foreach (writes[i]) begin
         csr_we    <= 1'b1;
         csr_index <= writes[i].idx;
         csr_wdata <= writes[i].val;
         @(posedge clock);
         case (writes[i].idx) inside
            CSR_CELL_A, CSR_CELL_B, CSR_CELL_C:
               cell_m[writes[i].idx] = writes[i].val;
            CSR_INV_0, CSR_INV_1, CSR_INV_2:
               inv_m[writes[i].idx - CSR_INV_0] = writes[i].val;
            CSR_MASK:
               mask_m = writes[i].val[MASK_W-1:0];
            default: ;   // no register there, write dropped
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // One random phase: pick a cell setting, load all registers, stream items.
   task automatic run_phase(int p);
      cfg_type           regs [7];
      csr_write_type     writes [$];
      logic [MASK_W-1:0] m;
      int unsigned       span;
      int                lx, ly, lz, edge_len;
      real               bx, cx, cy;
      m  = $urandom_range(1, 7);
      lx = 1 << $urandom_range(0, 3);
      ly = 1 << $urandom_range(0, 3);
      lz = 1 << $urandom_range(0, 3);
      span = 16 << POS_FRAC;
      case (p)
         // orthorhombic box with an exact inverse
         0, 1, 8: begin
            regs[0] = pack_entries(lx * UNIT, 0, 0);
            regs[1] = pack_entries(0, ly * UNIT, 0);
            regs[2] = pack_entries(0, 0, lz * UNIT);
            regs[3] = pack_entries(UNIT / lx, 0, 0);
            regs[4] = pack_entries(0, UNIT / ly, 0);
            regs[5] = pack_entries(0, 0, UNIT / lz);
            if (p == 0) m = '1;
         end
         // skewed cell: upper-triangular matrix, inverse worked out here
         2, 7: begin
            edge_len = 4;
            bx = (real'($urandom_range(0, 2000)) / 1000.0 - 1.0) * edge_len / 2.0;
            cx = (real'($urandom_range(0, 2000)) / 1000.0 - 1.0) * edge_len / 2.0;
            cy = (real'($urandom_range(0, 2000)) / 1000.0 - 1.0) * edge_len / 2.0;
            regs[0] = pack_entries(edge_len * UNIT, 0, 0);
            regs[1] = pack_entries(to_matrix_fixed(bx), edge_len * UNIT, 0);
            regs[2] = pack_entries(to_matrix_fixed(cx), to_matrix_fixed(cy), edge_len * UNIT);
            regs[3] = pack_entries(UNIT / edge_len,
                                   to_matrix_fixed(-bx / (edge_len * edge_len)),
                                   to_matrix_fixed((bx * cy - cx * edge_len) /
                                                   (edge_len * edge_len * edge_len)));
            regs[4] = pack_entries(0, UNIT / edge_len,
                                   to_matrix_fixed(-cy / (edge_len * edge_len)));
            regs[5] = pack_entries(0, 0, UNIT / edge_len);
            if (p == 2) m = '1;
         end
         // largest positive entries everywhere
         4: begin
            for (int i = 0; i < 6; i++)
               regs[i] = pack_entries(1048575, 1048575, 1048575);
            m = '1;
            span = 1 << 29;
         end
         // most negative entries everywhere
         5: begin
            for (int i = 0; i < 6; i++)
               regs[i] = pack_entries(-1048576, -1048576, -1048576);
            span = 1 << 29;
         end
         // identity again, as after reset
         9: begin
            for (int i = 0; i < 3; i++) begin
               regs[i]     = unit_column(i);
               regs[i + 3] = unit_column(i);
            end
            m = '1;
            span = 4 << POS_FRAC;
         end
         // junk matrices; phase 3 is the open system, where they must not matter
         default: begin
            for (int i = 0; i < 6; i++) regs[i] = cfg_type'({$urandom, $urandom});
            m = (p == 3) ? '0 : MASK_W'($urandom_range(0, 7));
            span = 1 << 29;
         end
      endcase
      // mask written with random upper bits in some phases; they must be ignored
      regs[6] = (p == 5 || p == 6) ? cfg_type'({$urandom, $urandom}) : '0;
      regs[6][MASK_W-1:0] = m;

      for (int i = 0; i < 7; i++) writes.push_back('{csr_index_type'(i), regs[i]});
      if (p == 4) writes.push_back('{CSR_UNUSED, cfg_type'({$urandom, $urandom})});
      write_csrs(writes);

      // idling on both sides except in the burst phase; pressure phase sends back to back
      send_idle_on = (p != 0 && p != 8);
      rsp_idle_on <= (p != 8);
      if (p == 0) pressure_count <= pressure_count + 1;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) offer_pair(rand_pair(span), 1'b0, '0);
      settle();
   endtask

   // ---------------------------------------------------------------- processes

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: check each accepted result, then decide ready for the next edge
   initial begin
      int             stall_left;
      int             hold_left;
      int             pressure_seen;
      separation_type want;
      stall_left    = 0;
      hold_left     = 0;
      pressure_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_seps.size() == 0) begin
               report_mismatch("result with nothing pending", {rsp_ch.sep_x}, '0);
            end else begin
               want = expected_seps.pop_front();
               if (rsp_ch.sep_x !== want.x) report_mismatch("sep_x", rsp_ch.sep_x, want.x);
               if (rsp_ch.sep_y !== want.y) report_mismatch("sep_y", rsp_ch.sep_y, want.y);
               if (rsp_ch.sep_z !== want.z) report_mismatch("sep_z", rsp_ch.sep_z, want.z);
            end
            results_seen++;
         end
         if (pressure_count != pressure_seen) begin
            pressure_seen = pressure_count;
            hold_left     = HOLD_CYCLES;   // long hold-off so the pipeline backs up
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (rsp_idle_on && $urandom_range(0, 3) == 0) stall_left = idle_gap();
         end
      end
   end

   // watchdog: too long with no item moving on either side ends the run
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      csr_write_type mask_write [$];
      req_ch.valid    <= 1'b0;
      req_ch.first_x  <= '0;
      req_ch.first_y  <= '0;
      req_ch.first_z  <= '0;
      req_ch.second_x <= '0;
      req_ch.second_y <= '0;
      req_ch.second_z <= '0;
      csr_we          <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         cell_m[i] = unit_column(i);
         inv_m[i]  = unit_column(i);
      end
      mask_m = '1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; the mask is changed between groups once the pipe is empty
      send_idle_on = 1'b1;
      rsp_idle_on <= 1'b1;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].mask != mask_m) begin
            settle();
            mask_write.delete();
            mask_write.push_back('{CSR_MASK, cfg_type'(directed_rows[i].mask)});
            write_csrs(mask_write);
         end
         offer_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].sep);
      end
      settle();

      for (int p = 0; p < PHASES; p++) run_phase(p);

      // quiet tail: nothing else may come out
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatches == 0 && expected_seps.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
